// ----- sv/xbr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package xbr_pkg;

  // link control characters
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [7:0] CH_C   = 8'h43;
  localparam logic [7:0] CH_SUB = 8'd26;

  // input kinds
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_BYTE  = 1'b1;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_USE_CRC  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CRC_POLY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CRC_INIT = 2'd2;

  localparam logic [15:0] CRC_POLY_RST = 16'h8005;
  localparam logic [15:0] CRC_INIT_RST = 16'hFFFF;

  typedef struct packed {
    logic        use_crc;
    logic [15:0] crc_poly;
    logic [15:0] crc_init;
  } cfg_t;

  typedef struct packed {
    logic [7:0] keep_count;
    logic       finished;
    logic       block_good;
    logic       block_end;
    logic [7:0] data_byte;
    logic       data_valid;
    logic [7:0] tx_byte;
    logic       tx_valid;
  } res_t;

endpackage

`default_nettype wire

// ----- sv/xbr_crc_byte.sv -----
`timescale 1ns / 1ps
`default_nettype none

// one byte of msb-first crc16, byte zero-extended into the top
module xbr_crc_byte (
  input  wire logic [15:0] crc_in,
  input  wire logic [7:0]  data_in,
  input  wire logic [15:0] poly,
  output logic      [15:0] crc_out
);

  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {data_in, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ poly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule

`default_nettype wire

// ----- sv/xbr_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module xbr_ctrl #(
  parameter int unsigned BLOCK_BYTES = 128
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          step,
  input  wire logic          step_mode,
  input  wire logic [7:0]    step_byte,
  input  wire xbr_pkg::cfg_t cfg,
  output xbr_pkg::res_t      res
);
  import xbr_pkg::*;

  localparam int unsigned CW = $clog2(BLOCK_BYTES + 1);
  localparam logic [CW-1:0] BLK      = CW'(BLOCK_BYTES);
  localparam logic [CW-1:0] BLK_LAST = CW'(BLOCK_BYTES - 1);

  localparam logic [3:0] PH_IDLE      = 4'd0;
  localparam logic [3:0] PH_FIRST     = 4'd1;
  localparam logic [3:0] PH_HDR1      = 4'd2;
  localparam logic [3:0] PH_HDR2      = 4'd3;
  localparam logic [3:0] PH_DATA      = 4'd4;
  localparam logic [3:0] PH_CHK1      = 4'd5;
  localparam logic [3:0] PH_CHK2      = 4'd6;
  localparam logic [3:0] PH_AFTER_ACK = 4'd7;
  localparam logic [3:0] PH_DONE      = 4'd8;

  logic [3:0]    phase_r, phase_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] pad_r, pad_nxt;
  logic [15:0]   crc_r, crc_nxt;
  logic [7:0]    sum_r, sum_nxt;
  logic [7:0]    chk_lo_r, chk_lo_nxt;
  logic [15:0]   crc_upd;
  logic [CW-1:0] keep_full;

  xbr_crc_byte u_crc (
    .crc_in  (crc_r),
    .data_in (step_byte),
    .poly    (cfg.crc_poly),
    .crc_out (crc_upd)
  );

  assign keep_full = BLK - pad_r;

  always_comb begin
    phase_nxt  = phase_r;
    idx_nxt    = idx_r;
    pad_nxt    = pad_r;
    crc_nxt    = crc_r;
    sum_nxt    = sum_r;
    chk_lo_nxt = chk_lo_r;
    res        = '0;
    if (step_mode == MODE_START) begin
      res.tx_valid = 1'b1;
      res.tx_byte  = cfg.use_crc ? CH_C : CH_NAK;
      phase_nxt    = PH_FIRST;
    end else begin
      case (phase_r)
        PH_AFTER_ACK, PH_FIRST: begin
          if (phase_r == PH_AFTER_ACK && step_byte == CH_EOT) begin
            res.tx_valid   = 1'b1;
            res.tx_byte    = CH_ACK;
            res.finished   = 1'b1;
            res.keep_count = keep_full[7:0];
            phase_nxt      = PH_DONE;
          end else begin
            phase_nxt = PH_HDR1;
          end
        end
        PH_HDR1: phase_nxt = PH_HDR2;
        PH_HDR2: begin
          idx_nxt    = '0;
          crc_nxt    = cfg.crc_init;
          sum_nxt    = '0;
          chk_lo_nxt = '0;
          pad_nxt    = '0;
          phase_nxt  = PH_DATA;
        end
        PH_DATA: begin
          res.data_valid = 1'b1;
          res.data_byte  = step_byte;
          crc_nxt        = crc_upd;
          sum_nxt        = sum_r + step_byte;
          pad_nxt        = (step_byte == CH_SUB) ? pad_r + 1'b1 : '0;
          idx_nxt        = idx_r + 1'b1;
          if (idx_r == BLK_LAST) begin
            phase_nxt = PH_CHK1;
          end
        end
        PH_CHK1: begin
          chk_lo_nxt = step_byte;
          if (cfg.use_crc) begin
            phase_nxt = PH_CHK2;
          end else begin
            res.tx_valid   = 1'b1;
            res.block_end  = 1'b1;
            res.block_good = (step_byte == sum_r);
            res.tx_byte    = res.block_good ? CH_ACK : CH_NAK;
            phase_nxt      = res.block_good ? PH_AFTER_ACK : PH_FIRST;
          end
        end
        PH_CHK2: begin
          res.tx_valid   = 1'b1;
          res.block_end  = 1'b1;
          res.block_good = ({step_byte, chk_lo_r} == crc_r);
          res.tx_byte    = res.block_good ? CH_ACK : CH_NAK;
          phase_nxt      = res.block_good ? PH_AFTER_ACK : PH_FIRST;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      idx_r    <= '0;
      pad_r    <= '0;
      crc_r    <= CRC_INIT_RST;
      sum_r    <= '0;
      chk_lo_r <= '0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      idx_r    <= idx_nxt;
      pad_r    <= pad_nxt;
      crc_r    <= crc_nxt;
      sum_r    <= sum_nxt;
      chk_lo_r <= chk_lo_nxt;
    end
  end

  a_start_goes_first: assert property (@(posedge clk) disable iff (!rst_n)
    step && step_mode == MODE_START |=> phase_r == PH_FIRST)
    else $error("start word did not return to first-byte phase");

  a_data_stays_or_checks: assert property (@(posedge clk) disable iff (!rst_n)
    step && step_mode == MODE_BYTE && phase_r == PH_DATA
    |=> phase_r == PH_DATA || phase_r == PH_CHK1)
    else $error("data phase left to an unexpected phase");

  a_index_in_block: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> idx_r < BLK)
    else $error("byte index ran past the block");

  a_pad_in_block: assert property (@(posedge clk) disable iff (!rst_n)
    pad_r <= idx_r || phase_r != PH_DATA)
    else $error("pad run longer than bytes seen");

endmodule

`default_nettype wire

// ----- sv/xmodem_block_receiver_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// xmodem-style block receiver: one word on the in_ side is either a start
// request (in_tuser low) or one byte taken off the link (in_tuser high). every
// accepted word gives exactly one out_ word carrying the control byte to send
// back (C, NAK or ACK), a streamed payload byte, the block verdict and, after
// EOT, the count of bytes to keep from the last good block. payload bytes are
// streamed before their block is checked, so a consumer must drop them when
// block_end arrives with block_good low. a new word can be accepted every
// cycle unless the output stalls; a word passes the input register, then the
// control step into the output register. the throughput limit is one control
// step per cycle, whose longest path is the unrolled 8-bit crc update. the user
// must write configuration only while the block is idle; nothing enforces it.
module xmodem_block_receiver_top #(
  parameter int unsigned BLOCK_BYTES = 128
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // configuration write port
  input  wire logic                          cfg_we,
  input  wire logic [xbr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]                   cfg_wdata,
  // input stream
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [7:0]                    in_tdata,  // [7:0] rx_byte
  input  wire logic                          in_tuser,  // [0] mode
  // result stream
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // [0] tx_valid, [8:1] tx_byte, [9] data_valid, [17:10] data_byte,
  // [18] block_end, [19] block_good, [20] finished, [28:21] keep_count,
  // [31:29] zero
  output logic [31:0]                        out_tdata
);
  import xbr_pkg::*;

  cfg_t       cfg_r;
  logic       in_valid_r;
  logic       in_mode_r;
  logic [7:0] in_byte_r;
  logic       out_valid_r;
  res_t       out_res_r;
  res_t       res;
  logic       advance;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.use_crc  <= 1'b0;
      cfg_r.crc_poly <= CRC_POLY_RST;
      cfg_r.crc_init <= CRC_INIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_USE_CRC:  cfg_r.use_crc  <= cfg_wdata[0];
        REG_CRC_POLY: cfg_r.crc_poly <= cfg_wdata;
        REG_CRC_INIT: cfg_r.crc_init <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // the held word moves on when the output register is free or being drained
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_mode_r <= in_tuser;
      in_byte_r <= in_tdata;
    end
  end

  // protocol state and per-byte work
  xbr_ctrl #(
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .step_mode (in_mode_r),
    .step_byte (in_byte_r),
    .cfg       (cfg_r),
    .res       (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_res_r};

endmodule

`default_nettype wire

// ----- tb/xmodem_block_receiver_checker.sv -----
`timescale 1ns / 1ps

module xmodem_block_receiver_checker
  import xbr_pkg::*;
#(
  parameter int unsigned BLOCK_BYTES = 128
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_wdata,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [7:0]           in_tdata,
  input  logic                 in_tuser,
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [31:0]          out_tdata,
  output int                   fail_count,
  output int                   in_flight
);

  typedef enum logic [3:0] {
    RX_IDLE, RX_FIRST, RX_HDR1, RX_HDR2, RX_DATA, RX_CHK1, RX_CHK2, RX_AFTER_ACK, RX_DONE
  } rx_phase_t;

  cfg_t        cfg;
  rx_phase_t   phase;
  int unsigned byte_count;
  int unsigned pad_run;
  logic [15:0] crc_acc;
  logic [7:0]  sum_acc;
  logic [15:0] check_rx;
  res_t        reply_q[$];
  int          n_bad;

  initial begin
    fail_count = 0;
    in_flight  = 0;
    n_bad      = 0;
  end

  // one byte through the msb-first crc, byte zero-extended into the top half
  function automatic logic [15:0] crc_step(logic [15:0] crc, logic [15:0] poly,
                                           logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++)
      c = c[15] ? ((c << 1) ^ poly) : (c << 1);
    return c;
  endfunction

  function automatic res_t step_receiver(logic mode, logic [7:0] b);
    res_t r;
    logic decided;
    logic pass;
    r       = '0;
    decided = 1'b0;
    pass    = 1'b0;
    if (mode == MODE_START) begin
      r.tx_valid = 1'b1;
      r.tx_byte  = cfg.use_crc ? CH_C : CH_NAK;
      phase      = RX_FIRST;
    end else begin
      case (phase)
        RX_AFTER_ACK: begin
          if (b == CH_EOT) begin
            r.tx_valid   = 1'b1;
            r.tx_byte    = CH_ACK;
            r.finished   = 1'b1;
            r.keep_count = 8'(BLOCK_BYTES - pad_run);
            phase        = RX_DONE;
          end else begin
            phase = RX_HDR1;
          end
        end
        RX_FIRST: phase = RX_HDR1;
        RX_HDR1:  phase = RX_HDR2;
        RX_HDR2: begin
          byte_count = 0;
          pad_run    = 0;
          crc_acc    = cfg.crc_init;
          sum_acc    = 8'h00;
          check_rx   = 16'h0000;
          phase      = RX_DATA;
        end
        RX_DATA: begin
          r.data_valid = 1'b1;
          r.data_byte  = b;
          crc_acc      = crc_step(crc_acc, cfg.crc_poly, b);
          sum_acc      = sum_acc + b;
          pad_run      = (b == CH_SUB) ? pad_run + 1 : 0;
          byte_count++;
          if (byte_count >= BLOCK_BYTES)
            phase = RX_CHK1;
        end
        RX_CHK1: begin
          check_rx = {8'h00, b};
          if (cfg.use_crc) begin
            phase = RX_CHK2;
          end else begin
            decided = 1'b1;
            pass    = (check_rx == {8'h00, sum_acc});
          end
        end
        RX_CHK2: begin
          check_rx[15:8] = b;
          decided        = 1'b1;
          pass           = (check_rx == crc_acc);
        end
        default: ;
      endcase
    end
    if (decided) begin
      r.tx_valid   = 1'b1;
      r.tx_byte    = pass ? CH_ACK : CH_NAK;
      r.block_end  = 1'b1;
      r.block_good = pass;
      phase        = pass ? RX_AFTER_ACK : RX_FIRST;
    end
    return r;
  endfunction

  function automatic string show(res_t r);
    return $sformatf("tx %0b/%02h data %0b/%02h end %0b good %0b fin %0b keep %0d",
                     r.tx_valid, r.tx_byte, r.data_valid, r.data_byte,
                     r.block_end, r.block_good, r.finished, r.keep_count);
  endfunction

  always @(posedge clk) begin : watch
    res_t got;
    res_t want;
    if (!rst_n) begin
      cfg.use_crc  = 1'b0;
      cfg.crc_poly = CRC_POLY_RST;
      cfg.crc_init = CRC_INIT_RST;
      phase        = RX_IDLE;
      byte_count   = 0;
      pad_run      = 0;
      crc_acc      = CRC_INIT_RST;
      sum_acc      = 8'h00;
      check_rx     = 16'h0000;
      reply_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_USE_CRC:  cfg.use_crc  = cfg_wdata[0];
          REG_CRC_POLY: cfg.crc_poly = cfg_wdata;
          REG_CRC_INIT: cfg.crc_init = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        reply_q.push_back(step_receiver(in_tuser, in_tdata));
      if (out_tvalid && out_tready) begin
        got = res_t'(out_tdata[28:0]);
        if (reply_q.size() == 0) begin
          n_bad++;
          if (n_bad <= 10)
            $display("%0t: word with nothing predicted: %s", $realtime, show(got));
        end else begin
          want = reply_q.pop_front();
          if (out_tdata !== {3'b000, want}) begin
            n_bad++;
            if (n_bad <= 10)
              $display("%0t: mismatch\n  expected %s\n  actual   %s pad %0h",
                       $realtime, show(want), show(got), out_tdata[31:29]);
          end
        end
      end
    end
    fail_count <= n_bad;
    in_flight  <= reply_q.size();
  end

endmodule

// ----- tb/xmodem_block_receiver_top_tb.sv -----
`timescale 1ns / 1ps

module xmodem_block_receiver_top_tb;
  import xbr_pkg::*;

  localparam int unsigned BLOCK_BYTES = 128;
  // long receiver hold-off, enough to back the block up into its input
  localparam int          HOLD_CYCLES = 300;
  // random part stops at the first block boundary past this many words
  localparam int          WORD_BUDGET = 450;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [15:0]          cfg_wdata  = '0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [7:0]           in_tdata   = '0;  // [7:0] rx_byte
  logic                 in_tuser   = 1'b0;  // [0] mode
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  // [0] tx_valid, [8:1] tx_byte, [9] data_valid, [17:10] data_byte,
  // [18] block_end, [19] block_good, [20] finished, [28:21] keep_count
  logic [31:0]          out_tdata;

  int fail_count;
  int in_flight;

  // sender and receiver pacing, shared between the stimulus and the sink
  bit tx_eager = 1'b0;
  bit rx_eager = 1'b0;
  bit hold_req = 1'b0;
  int words_sent = 0;

  // what the block is currently programmed with, needed to build check bytes
  logic        cur_crc  = 1'b0;
  logic [15:0] cur_poly = CRC_POLY_RST;
  logic [15:0] cur_init = CRC_INIT_RST;

  always #6 clk = ~clk;

  xmodem_block_receiver_top #(.BLOCK_BYTES(BLOCK_BYTES)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // watches all three ports, predicts every result word and compares
  xmodem_block_receiver_checker #(.BLOCK_BYTES(BLOCK_BYTES)) chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_count (fail_count),
    .in_flight  (in_flight)
  );

  // offer one word after a random gap and hold it until it is taken
  task automatic send_word(input logic mode, input logic [7:0] b);
    int gap;
    gap = tx_eager ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
  endtask

  // registers only change with the pipe drained; all three are written each time
  task automatic program_cfg(input logic crc, input logic [15:0] poly,
                             input logic [15:0] init);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_USE_CRC;
    cfg_wdata <= {15'h0000, crc};
    @(posedge clk);
    cfg_index <= REG_CRC_POLY;
    cfg_wdata <= poly;
    @(posedge clk);
    cfg_index <= REG_CRC_INIT;
    cfg_wdata <= init;
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_crc  = crc;
    cur_poly = poly;
    cur_init = init;
  endtask

  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 3))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // one whole block: first byte, two header bytes, payload, check byte(s).
  // flip toggles the check mode after the payload, before the first check byte
  task automatic send_block(input logic [7:0] first, input bit all_pad,
                            input bit good, input bit flip);
    logic [15:0] crc_run;
    logic [7:0]  sum_run;
    logic [15:0] check;
    logic [7:0]  b;
    int          pad_len;
    crc_run = cur_init;
    sum_run = 8'h00;
    pad_len = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 5);
    send_word(MODE_BYTE, first);
    send_word(MODE_BYTE, 8'($urandom));
    send_word(MODE_BYTE, 8'($urandom));
    for (int i = 0; i < BLOCK_BYTES; i++) begin
      if (all_pad || i >= BLOCK_BYTES - pad_len) begin
        b = CH_SUB;
      end else begin
        case ($urandom_range(0, 7))
          0:       b = 8'h00;
          1:       b = 8'hFF;
          2:       b = CH_SUB;  // pad inside the block, not trailing
          default: b = 8'($urandom);
        endcase
      end
      crc_run = chk.crc_step(crc_run, cur_poly, b);
      sum_run = sum_run + b;
      send_word(MODE_BYTE, b);
    end
    // check byte count follows the mode seen at the first check byte
    if (flip)
      program_cfg(!cur_crc, cur_poly, cur_init);
    check = cur_crc ? crc_run : {8'h00, sum_run};
    if (!good)
      check = check ^ (cur_crc ? 16'($urandom_range(1, 65535))
                               : {8'h00, 8'($urandom_range(1, 255))});
    send_word(MODE_BYTE, check[7:0]);
    if (cur_crc)
      send_word(MODE_BYTE, check[15:8]);
  endtask

  // result sink: random ready gaps, plus one long hold-off on request
  initial begin : sink
    int gap;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      gap = rx_eager ? 0 : $urandom_range(0, 10);
      if (gap != 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  // hard stop in case a handshake never comes
  initial begin : watchdog
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    int          blk;
    int          xfer;
    bit          done;
    bit          after_ack;
    bit          good;
    logic [7:0]  first;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed part ----
    // bytes while idle are ignored and give an all-zero word
    send_word(MODE_BYTE, 8'h00);
    send_word(MODE_BYTE, 8'hFF);
    send_word(MODE_BYTE, CH_EOT);
    // start in checksum mode (reset value) answers NAK
    send_word(MODE_START, 8'hFF);
    // crc mode with zero poly and start value, start answers 'C'
    program_cfg(1'b1, 16'h0000, 16'h0000);
    send_word(MODE_START, 8'h00);
    // partial block, then a start in the middle of the payload aborts it
    send_word(MODE_BYTE, 8'hFF);
    send_word(MODE_BYTE, 8'h00);
    send_word(MODE_BYTE, 8'hAA);
    send_word(MODE_BYTE, 8'h00);
    send_word(MODE_BYTE, 8'hFF);
    send_word(MODE_BYTE, CH_SUB);
    send_word(MODE_BYTE, CH_SUB);
    send_word(MODE_START, 8'h55);
    // EOT as a first byte is just skipped, a start during the header aborts
    send_word(MODE_BYTE, CH_EOT);
    send_word(MODE_BYTE, CH_ACK);
    send_word(MODE_START, 8'h00);

    // ---- random part: transfers of whole blocks with random content ----
    // block 0: good, long sink hold-off with the sender flat out
    // block 1: follows an ACK with a non-EOT first byte, check made bad
    // block 2: EOT as first byte after NAK, all pad, check mode flipped
    //          after the payload, good, then EOT so keep_count is zero
    // later blocks: random mode, good or bad, pad and pacing
    blk  = 0;
    xfer = 0;
    while (words_sent < WORD_BUDGET) begin
      case (xfer)
        0:       program_cfg(1'b1, CRC_POLY_RST, CRC_INIT_RST);
        1:       program_cfg(1'b0, 16'hFFFF, 16'h0000);
        default: program_cfg(1'($urandom), pick16(), pick16());
      endcase
      send_word(MODE_START, 8'($urandom));
      after_ack = 1'b0;
      done      = 1'b0;
      while (!done) begin
        if (after_ack) begin
          first = 8'($urandom);
          if (first == CH_EOT)
            first = first + 8'd1;
        end else begin
          first = (blk == 2) ? CH_EOT : 8'($urandom);
        end
        good     = (blk == 1) ? 1'b0 : (blk < 3 || $urandom_range(0, 3) != 0);
        tx_eager = (blk == 0) || ($urandom_range(0, 2) == 0);
        rx_eager = (blk != 0) && ($urandom_range(0, 2) == 0);
        if (blk == 0)
          hold_req = 1'b1;
        send_block(first, (blk == 2) || ($urandom_range(0, 9) == 0), good, blk == 2);
        after_ack = good;
        if (good && blk >= 2) begin
          // end of transfer, then a few stray bytes after the finish
          send_word(MODE_BYTE, CH_EOT);
          repeat ($urandom_range(1, 2)) send_word(MODE_BYTE, 8'($urandom));
          done = 1'b1;
        end else if (words_sent >= WORD_BUDGET) begin
          done = 1'b1;
        end
        blk++;
      end
      xfer++;
    end

    // drain the two-stage pipe, then the verdict
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fail_count == 0 && in_flight == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
